FILE: rtl/ctbd_pkg.sv
// ----------------------------------------------------------------------------
// ctbd_pkg
// Shared constants, types and constant-divisor helpers for the block decoder.
// ----------------------------------------------------------------------------
package ctbd_pkg;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT5 = 2'd1;
  localparam logic [1:0] FMT_ATI2 = 2'd2;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic CFG_IDX_FORMAT = 1'b0;

  localparam int TEXELS = 16;
  localparam int CNT_W  = $clog2(TEXELS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TEXELS - 1);

  localparam logic [7:0] BLUE_ATI2  = 8'd128;
  localparam logic [7:0] FULL_LEVEL = 8'd255;

  typedef logic [3:0][7:0] cpal_t;
  typedef logic [7:0][7:0] lpal_t;
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    cpal_t        red;
    cpal_t        green;
    cpal_t        blue;
    lpal_t        lev_a;
    lpal_t        lev_b;
    logic         four;
    logic [31:0]  cidx;
    logic [47:0]  aidx;
    logic [47:0]  bidx;
  } pal_set_t;

  // floor(x/d) with m = floor(2^s/d) and x < 2^s; estimate is low by at most one
  function automatic logic [15:0] recip_div(input logic [15:0] x, input logic [15:0] d,
                                            input logic [15:0] m, input logic [4:0] s);
    logic [31:0] p;
    logic [15:0] q;
    logic [15:0] r;
    p = 32'(x) * 32'(m);
    q = 16'(p >> s);
    r = x - 16'(32'(q) * 32'(d));
    if (r >= d) q = q + 16'd1;
    return q;
  endfunction

  function automatic logic [7:0] exp5(input logic [4:0] v);
    return 8'(recip_div(16'({v, 8'd0}) - 16'(v), 16'd31, 16'd264, 5'd13));
  endfunction

  function automatic logic [7:0] exp6(input logic [5:0] v);
    return 8'(recip_div(16'({v, 8'd0}) - 16'(v), 16'd63, 16'd260, 5'd14));
  endfunction

  function automatic logic [7:0] div3(input logic [15:0] x);
    return 8'(recip_div(x, 16'd3, 16'd341, 5'd10));
  endfunction

  function automatic logic [7:0] div5(input logic [15:0] x);
    return 8'(recip_div(x, 16'd5, 16'd409, 5'd11));
  endfunction

  function automatic logic [7:0] div7(input logic [15:0] x);
    return 8'(recip_div(x, 16'd7, 16'd292, 5'd11));
  endfunction

endpackage

FILE: rtl/ctbd_if.sv
// ----------------------------------------------------------------------------
// ctbd_if
// Valid/ready channels: compressed block in, decoded texel out.
// ----------------------------------------------------------------------------
interface ctbd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_low;
  logic [63:0] block_high;

  modport source (output valid, output block_low, output block_high, input ready);
  modport sink   (input valid, input block_low, input block_high, output ready);
endinterface

interface ctbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [1:0] texel_row;
  logic [1:0] texel_col;
  logic       last;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output texel_row, output texel_col, output last, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input texel_row, input texel_col, input last, output ready);
endinterface

FILE: rtl/ctbd_color_lane.sv
// ----------------------------------------------------------------------------
// ctbd_color_lane
// One colour channel: two expanded endpoints to a registered 4-entry palette.
// ----------------------------------------------------------------------------
module ctbd_color_lane (
  input  logic             clk,
  input  logic             en,
  input  logic [7:0]       e0,
  input  logic [7:0]       e1,
  input  logic             four,
  output ctbd_pkg::cpal_t  pal
);
  import ctbd_pkg::*;

  cpal_t pal_r;
  cpal_t pal_nxt;

  always_comb begin
    pal_nxt[0] = e0;
    pal_nxt[1] = e1;
    if (four) begin
      pal_nxt[2] = div3(16'({e0, 1'b0}) + 16'(e1));
      pal_nxt[3] = div3(16'(e0) + 16'({e1, 1'b0}));
    end else begin
      pal_nxt[2] = 8'((9'(e0) + 9'(e1)) >> 1);
      pal_nxt[3] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) pal_r <= pal_nxt;
  end

  assign pal = pal_r;

endmodule

FILE: rtl/ctbd_level_lane.sv
// ----------------------------------------------------------------------------
// ctbd_level_lane
// One alpha-style channel: two 8-bit endpoints to a registered 8-level table.
// ----------------------------------------------------------------------------
module ctbd_level_lane (
  input  logic             clk,
  input  logic             en,
  input  logic [7:0]       v0,
  input  logic [7:0]       v1,
  output ctbd_pkg::lpal_t  lev
);
  import ctbd_pkg::*;

  lpal_t lev_r;
  lpal_t lev_nxt;

  always_comb begin
    lev_nxt    = '0;
    lev_nxt[0] = v0;
    lev_nxt[1] = v1;
    if (v0 > v1) begin
      for (int i = 1; i <= 6; i++) begin
        lev_nxt[1 + i] = div7(16'(7 - i) * 16'(v0) + 16'(i) * 16'(v1));
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        lev_nxt[1 + i] = div5(16'(5 - i) * 16'(v0) + 16'(i) * 16'(v1));
      end
      lev_nxt[6] = 8'd0;
      lev_nxt[7] = FULL_LEVEL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) lev_r <= lev_nxt;
  end

  assign lev = lev_r;

endmodule

FILE: rtl/ctbd_emit.sv
// ----------------------------------------------------------------------------
// ctbd_emit
// Merges lane palettes into registered texels, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ctbd_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         fmt,
  input  logic               s2_valid,
  input  ctbd_pkg::pal_set_t pal,
  output logic               done,
  ctbd_out_if.source         out_txl
);
  import ctbd_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_load;
  logic [7:0]       red_r, green_r, blue_r, alpha_r;
  logic [7:0]       red_nxt, green_nxt, blue_nxt, alpha_nxt;
  logic [1:0]       ci;
  logic [2:0]       ai;
  logic [2:0]       bi;
  logic [5:0]       lbase;

  assign out_load = s2_valid && (!out_valid_r || out_txl.ready);
  assign done     = out_load && (cnt_r == CNT_LAST);

  assign lbase = 6'({cnt_r, 1'b0}) + 6'(cnt_r);
  assign ci    = pal.cidx[{cnt_r, 1'b0} +: 2];
  assign ai    = pal.aidx[lbase +: 3];
  assign bi    = pal.bidx[lbase +: 3];

  always_comb begin
    red_nxt   = pal.red[ci];
    green_nxt = pal.green[ci];
    blue_nxt  = pal.blue[ci];
    alpha_nxt = FULL_LEVEL;
    case (fmt)
      FMT_DXT5: begin
        alpha_nxt = pal.lev_a[ai];
      end
      FMT_ATI2: begin
        red_nxt   = pal.lev_a[ai];
        green_nxt = pal.lev_b[bi];
        blue_nxt  = BLUE_ATI2;
      end
      default: begin
        if (!pal.four && ci == 2'd3) alpha_nxt = 8'd0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      cnt_nxt       = cnt_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_txl.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  logic [CNT_W-1:0] pos_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
      pos_r   <= cnt_r;
    end
  end

  assign out_txl.valid     = out_valid_r;
  assign out_txl.red       = red_r;
  assign out_txl.green     = green_r;
  assign out_txl.blue      = blue_r;
  assign out_txl.alpha     = alpha_r;
  assign out_txl.texel_row = pos_r[3:2];
  assign out_txl.texel_col = pos_r[1:0];
  assign out_txl.last      = (pos_r == CNT_LAST);

  a_done_has_block: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> s2_valid) else $error("block finished with no block held");

  a_mid_block_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> s2_valid) else $error("texel count running without a block");

  a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_txl.valid && out_txl.last) |->
      (out_txl.texel_row == 2'd3 && out_txl.texel_col == 2'd3))
    else $error("last flag away from final texel");

endmodule

FILE: rtl/compressed_texture_block_decoder_top.sv
// ----------------------------------------------------------------------------
// compressed_texture_block_decoder_top
// DXT1 / DXT5 / ATI2 4x4 block decoder with lane palettes and texel merge.
// ----------------------------------------------------------------------------
// A block passes the stage-one, palette and output registers to its first texel.
// Block rate is set by the output, one texel per cycle while the sink is ready.
// A new block is taken while the previous one is still being emitted.
// Reset: synchronous, clears all valid flags and sets the format to DXT1.
module compressed_texture_block_decoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  ctbd_in_if.sink                       in_blk,
  ctbd_out_if.source                    out_txl,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctbd_pkg::CFG_AW-1:0]   paddr,
  input  logic [ctbd_pkg::CFG_DW-1:0]   pwdata,
  output logic [ctbd_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import ctbd_pkg::*;

  logic [1:0]  fmt_r;
  logic [1:0]  fmt_nxt;
  logic        cfg_wr;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        s2_valid_r;
  logic        s2_valid_nxt;
  logic        in_take;
  logic        s2_load;
  logic        done;

  logic [31:0] cw;
  logic [15:0] e0;
  logic [15:0] e1;
  rgb_t        c0_nxt, c1_nxt;
  rgb_t        c0_r, c1_r;
  logic        four_nxt, s1_four_r, s2_four_r;
  logic [63:0] s1_lo_r, s1_hi_r;
  logic [31:0] s2_cidx_r;
  logic [47:0] s2_aidx_r, s2_bidx_r;
  cpal_t       cpal [3];
  lpal_t       lev_a, lev_b;
  pal_set_t    pal;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_FORMAT);
  assign prdata = (paddr[2] == CFG_IDX_FORMAT) ? CFG_DW'(fmt_r) : '0;

  always_comb begin
    fmt_nxt = fmt_r;
    if (cfg_wr) fmt_nxt = pwdata[1:0];
  end

  // pipeline control
  assign s2_load      = s1_valid_r && (!s2_valid_r || done);
  assign in_blk.ready = !s1_valid_r || s2_load;
  assign in_take      = in_blk.valid && in_blk.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s2_valid_nxt = s2_valid_r;
    if (in_take)      s1_valid_nxt = 1'b1;
    else if (s2_load) s1_valid_nxt = 1'b0;
    if (s2_load)      s2_valid_nxt = 1'b1;
    else if (done)    s2_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r      <= FMT_DXT1;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      fmt_r      <= fmt_nxt;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // endpoint expansion on the way in
  assign cw = (fmt_r == FMT_DXT5) ? in_blk.block_high[31:0] : in_blk.block_low[31:0];
  assign e0 = cw[15:0];
  assign e1 = cw[31:16];

  always_comb begin
    c0_nxt[2] = exp5(e0[15:11]);
    c0_nxt[1] = exp6(e0[10:5]);
    c0_nxt[0] = exp5(e0[4:0]);
    c1_nxt[2] = exp5(e1[15:11]);
    c1_nxt[1] = exp6(e1[10:5]);
    c1_nxt[0] = exp5(e1[4:0]);
    four_nxt  = (fmt_r == FMT_DXT5) || (e0 > e1);
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      c0_r      <= c0_nxt;
      c1_r      <= c1_nxt;
      s1_four_r <= four_nxt;
      s1_lo_r   <= in_blk.block_low;
      s1_hi_r   <= in_blk.block_high;
    end
  end

  // palette lanes
  for (genvar ch = 0; ch < 3; ch++) begin : g_color
    ctbd_color_lane u_color (
      .clk  (clk),
      .en   (s2_load),
      .e0   (c0_r[ch]),
      .e1   (c1_r[ch]),
      .four (s1_four_r),
      .pal  (cpal[ch])
    );
  end

  ctbd_level_lane u_level_a (
    .clk (clk),
    .en  (s2_load),
    .v0  (s1_lo_r[7:0]),
    .v1  (s1_lo_r[15:8]),
    .lev (lev_a)
  );

  ctbd_level_lane u_level_b (
    .clk (clk),
    .en  (s2_load),
    .v0  (s1_hi_r[7:0]),
    .v1  (s1_hi_r[15:8]),
    .lev (lev_b)
  );

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_four_r <= s1_four_r;
      s2_cidx_r <= (fmt_r == FMT_DXT5) ? s1_hi_r[63:32] : s1_lo_r[63:32];
      s2_aidx_r <= s1_lo_r[63:16];
      s2_bidx_r <= s1_hi_r[63:16];
    end
  end

  always_comb begin
    pal.red   = cpal[2];
    pal.green = cpal[1];
    pal.blue  = cpal[0];
    pal.lev_a = lev_a;
    pal.lev_b = lev_b;
    pal.four  = s2_four_r;
    pal.cidx  = s2_cidx_r;
    pal.aidx  = s2_aidx_r;
    pal.bidx  = s2_bidx_r;
  end

  ctbd_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .fmt      (fmt_r),
    .s2_valid (s2_valid_r),
    .pal      (pal),
    .done     (done),
    .out_txl  (out_txl)
  );

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r) else $error("accepted block not held");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_load) |=> s1_valid_r) else $error("waiting block dropped");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_blk.ready) else $error("input stalled with stage one empty");

endmodule
